// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; all checks sample on i_clk and are
// held off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every sampled edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/tcfo_pkg.sv
// ---------------------------------------------------------------------------
// tcfo_pkg
// Types and codes shared by the two-class FIFO block.
// ---------------------------------------------------------------------------
package tcfo_pkg;

    localparam int ID_WIDTH = 32;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] WANT_ANY = 2'd0;
    localparam logic [1:0] WANT_A   = 2'd1;
    localparam logic [1:0] WANT_B   = 2'd2;

    typedef enum logic [1:0] {
        ST_REMOVED = 2'd0,
        ST_STORED  = 2'd1,
        ST_DROPPED = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DECIDE
    } t_state;

    // per-queue commands from the sequencer
    typedef struct packed {
        logic rd;
        logic push;
        logic pop;
    } t_q_ctrl;

    // per-queue fill flags back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_flags;

endpackage

// File: rtl/core/two_class_fifo_oldest_dequeue.sv
// ---------------------------------------------------------------------------
// two_class_fifo_oldest_dequeue
// Two FIFOs of signed ids (class A: id >= 0, class B: id < 0) with removal
// by class or oldest-first across both, using wrapping arrival tags.
// ---------------------------------------------------------------------------
// Every input beat gives exactly one output beat. An arrival pushes its id,
// tagged with the running arrival sequence, into its class queue (status
// stored), or is dropped when that queue is full (status dropped, sequence
// unchanged). A removal pops class A, class B, or with "any" the head whose
// tag is older: B wins when (tagB - tagA) has its top bit set, so a tie goes
// to A. An empty class, both queues empty, or selector 3 gives no match and
// leaves the state alone. removed_id is zero unless status is removed.
// Steps: a read step issues the head reads of both queue RAMs on the
// accepting edge, and a decide step decides and writes back; the input is
// stalled meanwhile, so no new beat is taken until the item is written
// back. A finished result sits in the output register while the next beat
// is accepted and its heads are read; the decide step waits only if that
// register is still held by a stall. Queue RAMs need no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module two_class_fifo_oldest_dequeue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int SEQ_WIDTH   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_opcode,
    input  logic signed [tcfo_pkg::ID_WIDTH-1:0] i_item_id,
    input  logic [1:0]                           i_want_class,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_status,
    output logic signed [tcfo_pkg::ID_WIDTH-1:0] o_removed_id
);
    import tcfo_pkg::*;

    // sequencer
    t_state  r_state;
    t_state  n_state;
    logic    w_accept;
    logic    w_out_free;
    logic    w_commit;

    // captured beat
    logic                       r_op;
    logic signed [ID_WIDTH-1:0] r_id;
    logic [1:0]                 r_want;

    // arrival tag counter
    logic [SEQ_WIDTH-1:0] r_seq;

    // queue interfaces
    t_q_ctrl               w_ctrl_a;
    t_q_ctrl               w_ctrl_b;
    t_q_flags              w_flags_a;
    t_q_flags              w_flags_b;
    logic [ID_WIDTH-1:0]   w_head_id_a;
    logic [ID_WIDTH-1:0]   w_head_id_b;
    logic [SEQ_WIDTH-1:0]  w_head_seq_a;
    logic [SEQ_WIDTH-1:0]  w_head_seq_b;
    logic [SEQ_WIDTH-1:0]  w_age_diff;

    // decision
    logic                 w_pick_a;
    logic                 w_pick_b;
    logic                 w_store;
    t_status              w_status;
    logic [ID_WIDTH-1:0]  w_removed;
    logic [3:0]           w_queue_ops;

    // output register
    logic                       r_out_valid;
    t_status                    r_status;
    logic signed [ID_WIDTH-1:0] r_removed_id;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_opcode;
            r_id   <= i_item_id;
            r_want <= i_want_class;
        end
    end

    // B is older when tagB - tagA (mod 2^SEQ_WIDTH) is negative
    assign w_age_diff = w_head_seq_b - w_head_seq_a;

    // decide: arrival store/drop, or which head to pop
    always_comb begin
        w_pick_a  = 1'b0;
        w_pick_b  = 1'b0;
        w_store   = 1'b0;
        w_status  = ST_NOMATCH;
        w_removed = '0;
        if (r_op == OP_ARRIVE) begin
            if (r_id[ID_WIDTH-1] ? w_flags_b.full : w_flags_a.full) begin
                w_status = ST_DROPPED;
            end else begin
                w_store  = 1'b1;
                w_status = ST_STORED;
            end
        end else begin
            case (r_want)
                WANT_A: begin
                    w_pick_a = !w_flags_a.empty;
                end
                WANT_B: begin
                    w_pick_b = !w_flags_b.empty;
                end
                WANT_ANY: begin
                    if (!w_flags_a.empty && !w_flags_b.empty) begin
                        w_pick_b = w_age_diff[SEQ_WIDTH-1];
                        w_pick_a = !w_age_diff[SEQ_WIDTH-1];
                    end else begin
                        w_pick_a = !w_flags_a.empty;
                        w_pick_b = !w_flags_b.empty;
                    end
                end
                default: begin
                    // selector 3: no match
                end
            endcase
            if (w_pick_a) begin
                w_status  = ST_REMOVED;
                w_removed = w_head_id_a;
            end else if (w_pick_b) begin
                w_status  = ST_REMOVED;
                w_removed = w_head_id_b;
            end
        end
    end

    // sequencer: next state and queue commands
    always_comb begin
        n_state       = r_state;
        w_commit      = 1'b0;
        w_ctrl_a      = '0;
        w_ctrl_b      = '0;
        w_ctrl_a.rd   = w_accept;
        w_ctrl_b.rd   = w_accept;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    w_commit      = 1'b1;
                    n_state       = S_IDLE;
                    w_ctrl_a.push = w_store && !r_id[ID_WIDTH-1];
                    w_ctrl_b.push = w_store && r_id[ID_WIDTH-1];
                    w_ctrl_a.pop  = w_pick_a;
                    w_ctrl_b.pop  = w_pick_b;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // tag advances only on a stored arrival
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (w_commit && w_store) begin
            r_seq <= r_seq + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_status     <= w_status;
            r_removed_id <= w_removed;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_removed_id = r_removed_id;

    tcfo_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SEQ_WIDTH   (SEQ_WIDTH)
    ) u_queue_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl_a),
        .i_wr_id    (r_id),
        .i_wr_seq   (r_seq),
        .o_head_id  (w_head_id_a),
        .o_head_seq (w_head_seq_a),
        .o_flags    (w_flags_a)
    );

    tcfo_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SEQ_WIDTH   (SEQ_WIDTH)
    ) u_queue_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl_b),
        .i_wr_id    (r_id),
        .i_wr_seq   (r_seq),
        .o_head_id  (w_head_id_b),
        .o_head_seq (w_head_seq_b),
        .o_flags    (w_flags_b)
    );

    assign w_queue_ops = {w_ctrl_a.push, w_ctrl_a.pop, w_ctrl_b.push, w_ctrl_b.pop};

    // never pop an empty queue or push a full one
    `ASSERT_ALWAYS(a_pop_a_ok, !(w_ctrl_a.pop && w_flags_a.empty), "pop on empty A")
    `ASSERT_ALWAYS(a_pop_b_ok, !(w_ctrl_b.pop && w_flags_b.empty), "pop on empty B")
    `ASSERT_ALWAYS(a_push_a_ok, !(w_ctrl_a.push && w_flags_a.full), "push on full A")
    `ASSERT_ALWAYS(a_push_b_ok, !(w_ctrl_b.push && w_flags_b.full), "push on full B")
    // at most one queue changes per item
    `ASSERT_ALWAYS(a_one_op, $onehot0(w_queue_ops), "more than one queue op")
    // a removed id is reported only with the removed status
    `ASSERT_IMPL(a_id_zero, o_out_valid && o_status != ST_REMOVED, o_removed_id == '0, "stray id")

endmodule

// File: rtl/core/tcfo_queue.sv
// ---------------------------------------------------------------------------
// tcfo_queue
// One circular queue: entry RAM (id + arrival tag), head pointer and fill
// count. Head entry is read on request into a register.
// ---------------------------------------------------------------------------
module tcfo_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int SEQ_WIDTH   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcfo_pkg::t_q_ctrl             i_ctrl,
    input  logic [tcfo_pkg::ID_WIDTH-1:0] i_wr_id,
    input  logic [SEQ_WIDTH-1:0]          i_wr_seq,
    output logic [tcfo_pkg::ID_WIDTH-1:0] o_head_id,
    output logic [SEQ_WIDTH-1:0]          o_head_seq,
    output tcfo_pkg::t_q_flags            o_flags
);
    import tcfo_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(2 * QUEUE_DEPTH);
    localparam int EW = ID_WIDTH + SEQ_WIDTH;

    logic [EW-1:0] r_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rd_data;
    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [PW-1:0] w_sum;
    logic [AW-1:0] w_tail;

    // tail = (head + count) mod depth; the sum stays below twice the depth
    assign w_sum  = PW'(r_head) + PW'(r_count);
    assign w_tail = (w_sum >= PW'(QUEUE_DEPTH)) ? AW'(w_sum - PW'(QUEUE_DEPTH))
                                                : AW'(w_sum);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctrl.pop) begin
            n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end else if (i_ctrl.push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[w_tail] <= {i_wr_id, i_wr_seq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_head_id     = r_rd_data[EW-1:SEQ_WIDTH];
    assign o_head_seq    = r_rd_data[SEQ_WIDTH-1:0];
    assign o_flags.empty = (r_count == '0);
    assign o_flags.full  = (r_count == CW'(QUEUE_DEPTH));

endmodule
